// ----- rtl/core/tsoe_pkg.sv -----
// Package for the two-stack operation engine: operation codes, status codes,
// per-stack micro-op commands and controller states.
// No dependencies.
package tsoe_pkg;

    localparam int WORD_W    = 32;
    localparam int OP_W      = 4;
    localparam int ST_W      = 2;
    localparam int DEPTH_DEF = 512;

    typedef enum logic [OP_W-1:0] {
        OP_SA    = 4'd0,
        OP_SB    = 4'd1,
        OP_SS    = 4'd2,
        OP_PA    = 4'd3,
        OP_PB    = 4'd4,
        OP_RA    = 4'd5,
        OP_RB    = 4'd6,
        OP_RRA   = 4'd7,
        OP_RRB   = 4'd8,
        OP_LOAD  = 4'd9,
        OP_CLEAR = 4'd10
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK   = 2'd0,
        ST_FEW  = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    // Micro-ops a single stack unit executes
    typedef enum logic [2:0] {
        STK_NONE,
        STK_SWAP,
        STK_ROT_UP,
        STK_ROT_DN,
        STK_POP,
        STK_PUSH,
        STK_LOAD,
        STK_CLEAR
    } stk_op_t;

    typedef struct packed {
        stk_op_t           op;
        logic [WORD_W-1:0] word;
    } stk_cmd_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_EXEC,
        FSM_WAIT
    } fsm_t;

endpackage

// ----- rtl/core/tsoe_ram.sv -----
// Generic single-write, single-read RAM with registered, read-first output.
// No dependencies.
module tsoe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old word when the same address is written
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/tsoe_stack.sv -----
// One ring-buffer stack: head, count and cached top word around a tsoe_ram.
// Depends on tsoe_pkg and tsoe_ram.
module tsoe_stack #(
    parameter int DEPTH = tsoe_pkg::DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  tsoe_pkg::stk_cmd_t                cmd,
    output logic [$clog2(DEPTH+1)-1:0]        count_o,
    output logic [tsoe_pkg::WORD_W-1:0]       top_o,
    output logic [$clog2(DEPTH+1)-1:0]        count_next_o,
    output logic [tsoe_pkg::WORD_W-1:0]       top_next_o
);
    import tsoe_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);
    localparam int SW = CW + 1;

    logic [AW-1:0]     head_reg, head_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [WORD_W-1:0] top_reg, top_next;
    stk_op_t           pend_reg, pend_next;

    logic              we;
    logic [AW-1:0]     waddr, raddr;
    logic [WORD_W-1:0] wdata, rdata;

    logic [AW-1:0]     inc, dec, tail, last;
    logic [SW-1:0]     sum_tail, sum_last;

    tsoe_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // ring index arithmetic, modulo DEPTH
    always_comb begin
        inc      = (head_reg == AW'(DEPTH-1)) ? '0 : head_reg + AW'(1);
        dec      = (head_reg == '0) ? AW'(DEPTH-1) : head_reg - AW'(1);
        sum_tail = SW'(head_reg) + SW'(count_reg);
        sum_last = sum_tail - SW'(1);
        tail     = (sum_tail >= SW'(DEPTH)) ? AW'(sum_tail - SW'(DEPTH)) : AW'(sum_tail);
        last     = (sum_last >= SW'(DEPTH)) ? AW'(sum_last - SW'(DEPTH)) : AW'(sum_last);
    end

    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        top_next   = top_reg;
        pend_next  = STK_NONE;
        we         = 1'b0;
        waddr      = inc;
        wdata      = top_reg;
        raddr      = inc;

        // on the command: issue the read, do any write that needs no read data
        case (cmd.op)
            STK_SWAP: begin
                we        = 1'b1;
                pend_next = STK_SWAP;
            end
            STK_ROT_UP: begin
                we        = 1'b1;
                waddr     = tail;
                pend_next = STK_ROT_UP;
            end
            STK_ROT_DN: begin
                raddr     = last;
                pend_next = STK_ROT_DN;
            end
            STK_POP: begin
                pend_next = STK_POP;
            end
            STK_PUSH: begin
                we         = 1'b1;
                waddr      = dec;
                wdata      = cmd.word;
                head_next  = dec;
                count_next = count_reg + CW'(1);
                top_next   = cmd.word;
            end
            STK_LOAD: begin
                we         = 1'b1;
                waddr      = tail;
                wdata      = cmd.word;
                count_next = count_reg + CW'(1);
                if (count_reg == '0) begin
                    top_next = cmd.word;
                end
            end
            STK_CLEAR: begin
                head_next  = '0;
                count_next = '0;
            end
            default: begin
            end
        endcase

        // on the pending micro-op: finish with the word read back
        case (pend_reg)
            STK_SWAP: begin
                we       = 1'b1;
                waddr    = head_reg;
                wdata    = rdata;
                top_next = rdata;
            end
            STK_ROT_UP: begin
                top_next  = rdata;
                head_next = inc;
            end
            STK_ROT_DN: begin
                we        = 1'b1;
                waddr     = dec;
                wdata     = rdata;
                top_next  = rdata;
                head_next = dec;
            end
            STK_POP: begin
                top_next   = rdata;
                head_next  = inc;
                count_next = count_reg - CW'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
            pend_reg  <= STK_NONE;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        top_reg <= top_next;
    end

    assign count_o      = count_reg;
    assign top_o        = top_reg;
    assign count_next_o = count_next;
    assign top_next_o   = top_next;

endmodule

// ----- rtl/core/two_stack_operation_engine_core.sv -----
// Top level of the two-stack operation engine: request decode, controller
// and result register around two tsoe_stack units.
// Depends on tsoe_pkg and tsoe_stack.
//
//  channel  | dir | ports        | contents
//  ---------+-----+--------------+--------------------------------------------
//  request  | in  | s_axis_*     | tuser: operation; tdata: value
//  result   | out | m_axis_*     | tdata: status, tops of A and B, both counts
//
// Every request issues the stack memory read (and any write not needing read
// data) as it is taken, then finishes with the word read in EXEC. A new request
// is taken in the cycle after the result is formed, even if that result has not
// yet been taken; a stalled result holds the controller until the register frees.
// Reset clears heads, counts and control; stack memories need no clearing.
module two_stack_operation_engine_core #(
    parameter int DEPTH = tsoe_pkg::DEPTH_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  logic [tsoe_pkg::WORD_W-1:0]             s_axis_tdata,  // [31:0] value
    input  logic [tsoe_pkg::OP_W-1:0]               s_axis_tuser,  // [3:0] operation
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // status, top_of_a, top_of_b, entries_in_a, entries_in_b, zero pad
    output logic [((2*tsoe_pkg::WORD_W+tsoe_pkg::ST_W
                    +2*$clog2(DEPTH+1)+7)/8)*8-1:0] m_axis_tdata
);
    import tsoe_pkg::*;

    localparam int CW       = $clog2(DEPTH+1);
    localparam int OUT_BITS = 2*WORD_W + ST_W + 2*CW;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    fsm_t              state_reg, state_next;
    status_t           status_reg, status_next;
    logic              m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]  m_data_reg, m_data_next;

    stk_cmd_t          cmd_a, cmd_b;
    logic [CW-1:0]     count_a, count_b, count_next_a, count_next_b;
    logic [WORD_W-1:0] top_a, top_b, top_next_a, top_next_b;

    logic              accept, out_free;
    logic              few_a, few_b, empty_a, empty_b, full_a, full_b;
    logic [WORD_W-1:0] res_top_a, res_top_b;

    tsoe_stack #(.DEPTH(DEPTH)) u_stack_a (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd_a),
        .count_o      (count_a),
        .top_o        (top_a),
        .count_next_o (count_next_a),
        .top_next_o   (top_next_a)
    );

    tsoe_stack #(.DEPTH(DEPTH)) u_stack_b (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd_b),
        .count_o      (count_b),
        .top_o        (top_b),
        .count_next_o (count_next_b),
        .top_next_o   (top_next_b)
    );

    assign s_axis_tready = (state_reg == FSM_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    assign few_a   = (count_a < CW'(2));
    assign few_b   = (count_b < CW'(2));
    assign empty_a = (count_a == '0);
    assign empty_b = (count_b == '0);
    assign full_a  = (count_a == CW'(DEPTH));
    assign full_b  = (count_b == CW'(DEPTH));

    // request decode: legality checks pick the stack micro-ops
    always_comb begin
        cmd_a       = '{op: STK_NONE, word: s_axis_tdata};
        cmd_b       = '{op: STK_NONE, word: s_axis_tdata};
        status_next = status_reg;
        if (accept) begin
            status_next = ST_OK;
            case (op_t'(s_axis_tuser))
                OP_SA: begin
                    if (few_a) status_next = ST_FEW;
                    else       cmd_a.op    = STK_SWAP;
                end
                OP_SB: begin
                    if (few_b) status_next = ST_FEW;
                    else       cmd_b.op    = STK_SWAP;
                end
                OP_SS: begin
                    if (!few_a) cmd_a.op = STK_SWAP;
                    if (!few_b) cmd_b.op = STK_SWAP;
                    if (few_a || few_b) status_next = ST_FEW;
                end
                OP_PA: begin
                    if (empty_b) begin
                        status_next = ST_FEW;
                    end else if (full_a) begin
                        status_next = ST_FULL;
                    end else begin
                        cmd_b.op   = STK_POP;
                        cmd_a.op   = STK_PUSH;
                        cmd_a.word = top_b;
                    end
                end
                OP_PB: begin
                    if (empty_a) begin
                        status_next = ST_FEW;
                    end else if (full_b) begin
                        status_next = ST_FULL;
                    end else begin
                        cmd_a.op   = STK_POP;
                        cmd_b.op   = STK_PUSH;
                        cmd_b.word = top_a;
                    end
                end
                OP_RA: begin
                    if (few_a) status_next = ST_FEW;
                    else       cmd_a.op    = STK_ROT_UP;
                end
                OP_RB: begin
                    if (few_b) status_next = ST_FEW;
                    else       cmd_b.op    = STK_ROT_UP;
                end
                OP_RRA: begin
                    if (few_a) status_next = ST_FEW;
                    else       cmd_a.op    = STK_ROT_DN;
                end
                OP_RRB: begin
                    if (few_b) status_next = ST_FEW;
                    else       cmd_b.op    = STK_ROT_DN;
                end
                OP_LOAD: begin
                    if (full_a) status_next = ST_FULL;
                    else        cmd_a.op    = STK_LOAD;
                end
                OP_CLEAR: begin
                    cmd_a.op = STK_CLEAR;
                    cmd_b.op = STK_CLEAR;
                end
                default: begin
                end
            endcase
        end
    end

    // next values equal current ones once the stacks are settled (WAIT)
    assign res_top_a = (count_next_a != '0) ? top_next_a : '0;
    assign res_top_b = (count_next_b != '0) ? top_next_b : '0;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_data_next  = m_data_reg;
        case (state_reg)
            FSM_IDLE: begin
                if (accept) state_next = FSM_EXEC;
            end
            FSM_EXEC, FSM_WAIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = OUT_W'({count_next_b, count_next_a,
                                           res_top_b, res_top_a, status_reg});
                    state_next   = FSM_IDLE;
                end else begin
                    state_next   = FSM_WAIT;
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= FSM_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_a <= CW'(DEPTH)) && (count_b <= CW'(DEPTH)))
        else $error("stack count exceeds depth");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_axis_tready)
        else $error("request taken while previous one executes");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> $past(state_reg == FSM_EXEC || state_reg == FSM_WAIT))
        else $error("result produced without a request in flight");

    a_stacks_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == FSM_WAIT) |-> (count_next_a == count_a && count_next_b == count_b))
        else $error("stack changed while result stalled");
`endif

endmodule
